FILE: rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register codes and word types of the masked byte
// signature scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // default sizing of the scanner
   localparam int MAX_PATTERN_BYTES_DEFAULT = 16;
   localparam int OFFSET_BITS_DEFAULT       = 32;

   // fixed field widths
   localparam int BYTE_BITS           = 8;
   localparam int CSR_DATA_BITS       = 64;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int CARE_MASK_BITS      = 16;
   localparam int PATTERN_LENGTH_BITS = 5;
   localparam int MATCH_OFFSET_BITS   = 32;

   // register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_CARE_MASK      = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   // input word
   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 last_byte;
   } req_payload_type;

   // result word
   typedef struct packed {
      logic                         found;
      logic [MATCH_OFFSET_BITS-1:0] match_offset;
   } rsp_payload_type;

endpackage

FILE: rtl/core/mbps_channel_if.sv
// ----------------------------------------------------------------------------
// mbps channel interfaces
// Valid/ready channels carrying input bytes and scan results.
// ----------------------------------------------------------------------------
interface mbps_req_if;
   logic                      valid;
   logic                      ready;
   mbps_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mbps_rsp_if;
   logic                      valid;
   logic                      ready;
   mbps_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/masked_byte_pattern_search_top.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// Streams a memory section one byte per word and scans it for a masked
// signature of up to MAX_PATTERN_BYTES bytes. The block takes one byte per
// clock when the result side keeps up: a byte is held in the input register,
// is compared against the signature in a single pass over the byte history
// window, and its result (if any) enters the output register when that is
// free. A section gives exactly one result word: found with the start offset
// at the first match, or not-found (offset 0) on the last byte of a section
// that never matched; later bytes of a matched section are dropped. Signature
// registers are to be written through the csr port only while the block is
// idle, not enforced by the block; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEFAULT,
   parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   // csr write port
   input  logic                                csr_write_enable,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_write_data,

   // byte stream in, result words out
   mbps_req_if.sink                            req_if,
   mbps_rsp_if.source                          rsp_if
);

   // history window keeps the previous bytes, newest at index 0
   localparam int WINDOW_DEPTH = MAX_PATTERN_BYTES - 1;
   localparam int FILL_BITS    = $clog2(MAX_PATTERN_BYTES);
   localparam int BB           = mbps_pkg::BYTE_BITS;
   localparam int PLB          = mbps_pkg::PATTERN_LENGTH_BITS;
   localparam int MOB          = mbps_pkg::MATCH_OFFSET_BITS;
   localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(WINDOW_DEPTH);

   // configuration registers
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  pattern_low_ff;
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  pattern_high_ff;
   logic [mbps_pkg::CARE_MASK_BITS-1:0] care_mask_ff;
   logic [PLB-1:0]                      pattern_length_ff;

   // input register
   logic          in_valid_ff;
   logic [BB-1:0] in_byte_ff;
   logic          in_last_ff;

   // section state
   logic [BB-1:0]          window_ff [WINDOW_DEPTH];
   logic [OFFSET_BITS-1:0] position_ff;
   logic [FILL_BITS-1:0]   fill_count_ff;
   logic                   match_reported_ff;

   // output register
   logic                      rsp_valid_ff;
   mbps_pkg::rsp_payload_type rsp_payload_ff;

   // handshake and datapath nets
   logic                   out_free;
   logic                   stage_fire;
   logic                   req_fire;
   logic                   result_load;
   logic [2*mbps_pkg::CSR_DATA_BITS-1:0] signature;
   logic [BB-1:0]          hist [MAX_PATTERN_BYTES];
   logic [FILL_BITS-1:0]   len_m1;
   logic [MAX_PATTERN_BYTES-1:0] mismatch;
   logic                   hit;
   logic [OFFSET_BITS-1:0] offset_wide;
   logic [63:0]            offset_ext;
   logic [MOB-1:0]         match_offset;

   // ------------------------------------------------------------------------
   // csr writes
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= PLB'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            mbps_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            mbps_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            mbps_pkg::CSR_CARE_MASK: begin
               care_mask_ff <= csr_write_data[mbps_pkg::CARE_MASK_BITS-1:0];
            end
            mbps_pkg::CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[PLB-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // flow control: the compare stage moves whenever the output register is
   // empty or being drained, so a stalled result still leaves the input
   // register room for one byte of buffering
   // ------------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign stage_fire   = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_fire     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_if.payload.data_byte;
         in_last_ff <= req_if.payload.last_byte;
      end
   end

   // ------------------------------------------------------------------------
   // compare pass
   // ------------------------------------------------------------------------
   assign signature = {pattern_high_ff, pattern_low_ff};

   // history seen from the current byte: index 0 is the byte itself
   always_comb begin
      hist[0] = in_byte_ff;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         hist[k] = window_ff[k-1];
      end
   end

   // active length minus one, with zero taken as one and overlong clamped
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_m1 = '0;
      end else if (pattern_length_ff > PLB'(MAX_PATTERN_BYTES)) begin
         len_m1 = FILL_MAX;
      end else begin
         len_m1 = FILL_BITS'(pattern_length_ff - PLB'(1));
      end
   end

   // signature byte j lines up with the byte len_m1 - j places back
   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         mismatch[j] = (FILL_BITS'(j) <= len_m1) && care_mask_ff[j] &&
                       (signature[BB*j +: BB] != hist[len_m1 - FILL_BITS'(j)]);
      end
   end

   assign hit = (fill_count_ff >= len_m1) && !(|mismatch);

   // match start, pinned at the top once the position counter saturates
   assign offset_wide  = (position_ff == '1) ? '1
                                             : position_ff - OFFSET_BITS'(len_m1);
   assign offset_ext   = 64'(offset_wide);
   assign match_offset = (offset_ext > 64'({MOB{1'b1}})) ? '1 : offset_ext[MOB-1:0];

   // one word per section: first match, or not-found on the last byte
   assign result_load = stage_fire && !match_reported_ff && (hit || in_last_ff);

   // ------------------------------------------------------------------------
   // section state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff       <= '0;
         fill_count_ff     <= '0;
         match_reported_ff <= 1'b0;
      end else if (stage_fire) begin
         if (in_last_ff) begin
            position_ff       <= '0;
            fill_count_ff     <= '0;
            match_reported_ff <= 1'b0;
         end else if (!match_reported_ff) begin
            if (position_ff != '1) begin
               position_ff <= position_ff + OFFSET_BITS'(1);
            end
            if (fill_count_ff != FILL_MAX) begin
               fill_count_ff <= fill_count_ff + FILL_BITS'(1);
            end
            match_reported_ff <= hit;
         end
      end
   end

   // window contents beyond the fill count are never looked at
   always_ff @(posedge clock) begin
      if (stage_fire && !in_last_ff && !match_reported_ff) begin
         window_ff[0] <= in_byte_ff;
         for (int k = 1; k < WINDOW_DEPTH; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result_load;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_payload_ff.found        <= hit;
         rsp_payload_ff.match_offset <= hit ? match_offset : '0;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   // a match inside a section silences the rest of it
   a_match_sets_flag : assert property (@(posedge clock) disable iff (reset)
      result_load && hit && !in_last_ff |=> match_reported_ff)
      else $error("match did not mark the section as reported");

   // the last byte always returns the section state to its start
   a_section_restart : assert property (@(posedge clock) disable iff (reset)
      stage_fire && in_last_ff |=>
         (fill_count_ff == '0) && (position_ff == '0) && !match_reported_ff)
      else $error("section state not cleared after last byte");

   // a not-found word carries a zero offset
   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.found |-> rsp_payload_ff.match_offset == '0)
      else $error("not-found word with nonzero offset");

endmodule

FILE: tb/sv/masked_byte_pattern_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top_tb
// Streams byte sections through the signature scanner and compares every
// result word against a cycle-free model of the scan kept in a scoreboard.
// A short directed part covers the length corner cases, wildcards, short
// sections, a match on the last byte and a register change mid-section;
// random sections with planted, broken and absent signatures follow under
// three idle and stall mixes.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top_tb;

   localparam int          SIG_BYTES     = mbps_pkg::MAX_PATTERN_BYTES_DEFAULT;
   localparam int          WINDOW_DEPTH  = SIG_BYTES - 1;
   localparam logic [31:0] OFFSET_MAX    = 32'hFFFF_FFFF;
   localparam int          RANDOM_BYTES  = 950;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          TAIL_CYCLES   = 20;
   localparam int          CYCLE_LIMIT   = 200000;

   // scan model and store of expected result words
   class signature_scoreboard;
      logic [63:0]               sig_low;
      logic [63:0]               sig_high;
      logic [15:0]               care;
      logic [4:0]                length_reg;
      logic [7:0]                window_bytes [WINDOW_DEPTH];
      logic [31:0]               position;
      int unsigned               filled;
      bit                        reported;
      mbps_pkg::rsp_payload_type expected_results [$];
      int unsigned               error_count;

      function void clear_section();
         foreach (window_bytes[i]) window_bytes[i] = 8'h00;
         position = '0;
         filled   = 0;
         reported = 1'b0;
      endfunction

      function void power_on();
         sig_low     = '0;
         sig_high    = '0;
         care        = '0;
         length_reg  = 5'd1;
         error_count = 0;
         expected_results.delete();
         clear_section();
      endfunction

      function void write_register(mbps_pkg::csr_index_type idx, logic [63:0] value);
         case (idx)
            mbps_pkg::CSR_PATTERN_LOW:    sig_low    = value;
            mbps_pkg::CSR_PATTERN_HIGH:   sig_high   = value;
            mbps_pkg::CSR_CARE_MASK:      care       = value[15:0];
            mbps_pkg::CSR_PATTERN_LENGTH: length_reg = value[4:0];
            default: ;
         endcase
      endfunction

      // bytes after a match only matter for their last-byte restart
      function void note_byte(logic [7:0] data, logic last);
         int unsigned               active_len;
         int unsigned               back;
         int                        j;
         bit                        hit;
         logic [7:0]                seen;
         logic [7:0]                wanted;
         mbps_pkg::rsp_payload_type result;
         if (!reported) begin
            active_len = (length_reg == 0) ? 1 :
                         (length_reg > SIG_BYTES) ? SIG_BYTES : length_reg;
            hit = (filled >= active_len - 1);
            for (j = 0; j < active_len; j++) begin
               back   = active_len - 1 - j;
               seen   = (back == 0) ? data : window_bytes[back - 1];
               wanted = (j < 8) ? sig_low[8*j +: 8] : sig_high[8*(j-8) +: 8];
               if (care[j] && seen != wanted) hit = 1'b0;
            end
            if (hit) begin
               result.found        = 1'b1;
               result.match_offset = (position == OFFSET_MAX) ? OFFSET_MAX :
                                     position - (active_len - 1);
               expected_results.push_back(result);
               reported = 1'b1;
            end else if (last) begin
               result = '0;
               expected_results.push_back(result);
            end
            if (!last) begin
               for (j = WINDOW_DEPTH - 1; j > 0; j--) window_bytes[j] = window_bytes[j-1];
               window_bytes[0] = data;
               if (filled < WINDOW_DEPTH) filled++;
               if (position != OFFSET_MAX) position++;
            end
         end
         if (last) clear_section();
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_result(mbps_pkg::rsp_payload_type got);
         mbps_pkg::rsp_payload_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word found=%0b offset=%0d",
                                      got.found, got.match_offset));
            return;
         end
         want = expected_results.pop_front();
         if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
         if (got.match_offset !== want.match_offset)
            report_mismatch($sformatf("match_offset %0d, expected %0d",
                                      got.match_offset, want.match_offset));
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [mbps_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   mbps_req_if req_chan ();
   mbps_rsp_if rsp_chan ();

   signature_scoreboard sb;

   // idle and stall percentages, one for each side of the block
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned sent_bytes;
   int unsigned cycle_count;

   // testbench copy of the signature, used only to plant matches
   logic [127:0] plant_bytes;
   logic [15:0]  plant_care;
   int unsigned  plant_len;

   masked_byte_pattern_search_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop if the run hangs
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side: check accepted words, then pick ready for the next edge
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            sb.check_result(rsp_chan.payload);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // one csr write; the caller lowers the enable after the last one
   task automatic write_csr(mbps_pkg::csr_index_type idx, logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic load_signature(logic [63:0] low, logic [63:0] high,
                                 logic [63:0] mask, logic [63:0] len);
      write_csr(mbps_pkg::CSR_PATTERN_LOW, low);
      write_csr(mbps_pkg::CSR_PATTERN_HIGH, high);
      write_csr(mbps_pkg::CSR_CARE_MASK, mask);
      write_csr(mbps_pkg::CSR_PATTERN_LENGTH, len);
      csr_write_enable <= 1'b0;
      plant_bytes = {high, low};
      plant_care  = mask[15:0];
      plant_len   = (len[4:0] == 0) ? 1 : (len[4:0] > SIG_BYTES) ? SIG_BYTES : len[4:0];
   endtask

   // send one word, idling first as the current mix says
   task automatic send_byte(logic [7:0] data, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= mbps_pkg::req_payload_type'{data_byte: data, last_byte: last};
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_byte(data, last);
      sent_bytes++;
   endtask

   // stop sending until every expected word is back and the pipe is empty
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_signature();
      logic [63:0] low;
      logic [63:0] high;
      logic [63:0] mask;
      logic [63:0] len;
      case ($urandom_range(9))
         0:       begin low = '0; high = '0; end
         1:       begin low = '1; high = '1; end
         default: begin low = {$urandom, $urandom}; high = {$urandom, $urandom}; end
      endcase
      case ($urandom_range(7))
         0:       mask = 64'h0;
         1:       mask = 64'hFFFF;
         default: mask = {48'h0, 16'($urandom)};
      endcase
      case ($urandom_range(9))
         0:       len = 64'd0;
         1:       len = 64'd16;
         2:       len = 64'd1;
         3:       len = 64'($urandom_range(17, 31));
         4, 5:    len = 64'($urandom_range(1, 4));
         default: len = 64'($urandom_range(1, 16));
      endcase
      // junk above the field width must be dropped by the block
      if ($urandom_range(3) == 0) mask[63:16] = {$urandom, 16'($urandom)};
      if ($urandom_range(3) == 0) len[63:5]   = {$urandom, 27'($urandom)};
      load_signature(low, high, mask, len);
   endtask

   // one section: mostly with a planted signature, some broken, some plain noise
   task automatic random_section();
      logic [7:0]  section_bytes [$];
      int unsigned count;
      int unsigned start;
      int unsigned flip;
      int unsigned kind;
      int unsigned i;
      kind  = $urandom_range(9);
      count = ($urandom_range(19) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
      for (i = 0; i < count; i++) section_bytes.push_back(8'($urandom));
      if (kind < 7 && count >= plant_len) begin
         start = $urandom_range(0, count - plant_len);
         for (i = 0; i < plant_len; i++)
            if (plant_care[i]) section_bytes[start + i] = plant_bytes[8*i +: 8];
         if (kind == 6) begin
            // near miss: disturb one byte of the planted signature
            flip = start + $urandom_range(0, plant_len - 1);
            section_bytes[flip] = section_bytes[flip] ^ (8'h01 << $urandom_range(7));
         end
      end
      for (i = 0; i < count; i++) send_byte(section_bytes[i], i == count - 1);
   endtask

   initial begin
      int unsigned j;
      int          phase;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= mbps_pkg::CSR_PATTERN_LOW;
      csr_write_data      <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.payload    <= '0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      sent_bytes          = 0;
      plant_bytes         = '0;
      plant_care          = '0;
      plant_len           = 1;
      sb = new;
      sb.power_on();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset signature is a single wildcard byte: first byte matches at 0,
      // rest of the section is dropped and its last byte restarts the scan
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // length zero acts as one; byte 0 must be 0xff
      wait_for_results();
      load_signature(64'h0000_0000_0000_00FF, 64'h0, 64'h1, 64'd0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      // length above the maximum acts as sixteen, all bytes cared
      wait_for_results();
      load_signature(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 64'hFFFF, 64'd31);
      // section shorter than the signature
      send_byte(8'hFF, 1'b1);
      // full signature ending on the section's last byte
      for (j = 0; j < SIG_BYTES; j++)
         send_byte(j < 8 ? 8'((64'h00FF_00FF_00FF_00FF >> (8*j))) :
                           8'((64'hFF00_FF00_FF00_FF00 >> (8*(j-8)))), j == SIG_BYTES - 1);

      // signature changes in the middle of a section, sender held off meanwhile
      wait_for_results();
      load_signature(64'h0000_0000_0000_00AB, 64'h0, 64'h1, 64'd1);
      send_byte(8'h12, 1'b0);
      wait_for_results();
      load_signature(64'h0000_0000_0000_0012, 64'h0, 64'h1, 64'd1);
      send_byte(8'h12, 1'b1);

      // random sections under three idle mixes
      sent_bytes = 0;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 28; receiver_stall_pct = 56; end
            1:       begin sender_idle_pct = 56; receiver_stall_pct = 28; end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         endcase
         while (sent_bytes < RANDOM_BYTES * (phase + 1) / 3) begin
            wait_for_results();
            random_signature();
            repeat ($urandom_range(3, 8))
               if (sent_bytes < RANDOM_BYTES * (phase + 1) / 3) random_section();
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
